// ===== hw/rtl/wildcard_glob_matcher_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the wildcard glob matcher
// Shared property forms, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// same-cycle implication, off during reset
`define WGM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wgm assertion failed");

// next-cycle implication, off during reset
`define WGM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wgm assertion failed");

// next-cycle implication that also covers reset cycles
`define WGM_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wgm reset assertion failed");

`endif

// ===== hw/rtl/wgm_pkg.sv =====
// ---------------------------------------------------------------------------
// Wildcard glob matcher package
// Sizes, request codes and the star-closure prefix network.
// ---------------------------------------------------------------------------
package wgm_pkg;

  localparam int MaxPattern   = 32;
  localparam int PosCount     = MaxPattern + 1;
  localparam int LenW         = $clog2(MaxPattern + 1);
  localparam int IdxW         = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int PrefixLevels = $clog2(PosCount);

  localparam int InDataW  = 8;
  localparam int InUserW  = 2;
  localparam int OutDataW = 8;

  localparam logic [7:0] StarChar = 8'd42;
  localparam logic [7:0] AnyChar  = 8'd63;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  // Bit j is set if seed bit j is set, or bit j-1 of the result is set and
  // prop bit j is set (prop[j]: pattern byte j-1 is a star). Log-depth scan.
  function automatic logic [PosCount-1:0] close_stars(input logic [PosCount-1:0] seed,
                                                      input logic [PosCount-1:0] prop);
    logic [PosCount-1:0] g;
    logic [PosCount-1:0] p;
    logic [PosCount-1:0] g_n;
    logic [PosCount-1:0] p_n;
    g = seed;
    p = prop;
    for (int k = 0; k < PrefixLevels; k++) begin
      for (int j = 0; j < PosCount; j++) begin
        if (j >= (1 << k)) begin
          g_n[j] = g[j] | (p[j] & g[j - (1 << k)]);
          p_n[j] = p[j] & p[j - (1 << k)];
        end else begin
          g_n[j] = g[j];
          p_n[j] = p[j];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

endpackage

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// ---------------------------------------------------------------------------
// Wildcard glob matcher
// Loads a '*'/'?' pattern byte by byte, streams text through a bit-parallel
// set of active pattern positions and reports the verdict on end of text.
// ---------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)              | tuser
//  s_*     | in  | char_byte[7:0]                  | action[1:0]
//  m_*     | out | matched, pattern_overflow, 0s   | -
//
//  One request per cycle, unless a waiting result stalls an end-of-text request.
//  Work per request: one input register, one position-vector update
//  (star closure as a log-depth prefix scan), one result register.
//  A waiting result stalls only an end-of-text request behind it.
//  rst clears pattern length, overflow flag, active set and both valids.
// ---------------------------------------------------------------------------
module wildcard_glob_matcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wgm_pkg::InDataW-1:0]   s_tdata,   // char_byte[7:0]
  input  logic [wgm_pkg::InUserW-1:0]   s_tuser,   // action[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wgm_pkg::OutDataW-1:0]  m_tdata    // [0] matched, [1] pattern_overflow
);
  import wgm_pkg::*;

  logic                  stg_valid;
  action_t               stg_action;
  logic [7:0]            stg_char;

  logic [7:0]            pat_char [MaxPattern];
  logic [MaxPattern-1:0] used;
  logic [LenW-1:0]       length;
  logic                  overflow;
  logic [PosCount-1:0]   active;

  logic                  out_matched;
  logic                  out_overflow;

  logic                  is_end;
  logic                  fire;
  logic                  full;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_idx;
  logic [MaxPattern-1:0] star_cur;
  logic [MaxPattern-1:0] hit_cur;
  logic [MaxPattern-1:0] stay;
  logic [MaxPattern-1:0] move;
  logic [MaxPattern-1:0] star_nx;
  logic [MaxPattern-1:0] used_nx;
  logic [PosCount-1:0]   step;
  logic [PosCount-1:0]   seed;
  logic [PosCount-1:0]   active_next;
  logic                  hit;

  assign is_end   = (stg_action == ACT_END);
  assign fire     = stg_valid && (!is_end || !m_tvalid || m_tready);
  assign s_tready = !stg_valid || fire;

  assign full   = (length == LenW'(MaxPattern));
  assign wr_en  = (stg_action == ACT_APPEND) && !full;
  assign wr_idx = length[IdxW-1:0];

  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      star_cur[i] = (pat_char[i] == StarChar);
      hit_cur[i]  = (pat_char[i] == AnyChar) || (pat_char[i] == stg_char);
      stay[i]     = active[i] && used[i] && star_cur[i];
      move[i]     = active[i] && used[i] && !star_cur[i] && hit_cur[i];
      if (wr_en && (wr_idx == IdxW'(i))) begin
        star_nx[i] = (stg_char == StarChar);
      end else begin
        star_nx[i] = star_cur[i];
      end
      if (stg_action == ACT_CLEAR) begin
        used_nx[i] = 1'b0;
      end else begin
        used_nx[i] = used[i] || (wr_en && (wr_idx == IdxW'(i)));
      end
    end
  end

  assign step        = {1'b0, stay} | {move, 1'b0};
  assign seed        = (stg_action == ACT_TEXT) ? step : PosCount'(1);
  assign active_next = close_stars(seed, {star_nx & used_nx, 1'b0});
  assign hit         = active[length] && !overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      length    <= '0;
      used      <= '0;
      overflow  <= 1'b0;
      active    <= PosCount'(1);
      m_tvalid  <= 1'b0;
    end else begin
      if (s_tready) begin
        stg_valid <= s_tvalid;
      end
      if (fire && is_end) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fire) begin
        active <= active_next;
        used   <= used_nx;
        case (stg_action)
          ACT_CLEAR: begin
            length   <= '0;
            overflow <= 1'b0;
          end
          ACT_APPEND: begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              length <= length + LenW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stg_action <= action_t'(s_tuser);
      stg_char   <= s_tdata;
    end
    if (fire && wr_en) begin
      pat_char[wr_idx] <= stg_char;
    end
    if (fire && is_end) begin
      out_matched  <= hit;
      out_overflow <= overflow;
    end
  end

  assign m_tdata = {(OutDataW - 2)'(0), out_overflow, out_matched};

endmodule

// ===== hw/rtl/wgm_checker.sv =====
// ---------------------------------------------------------------------------
// Wildcard glob matcher port checker
// Watches the top-level ports; bound to every matcher instance.
// ---------------------------------------------------------------------------
`include "wildcard_glob_matcher_assert.svh"

module wgm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [wgm_pkg::InUserW-1:0]   s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [wgm_pkg::OutDataW-1:0]  m_tdata
);
  import wgm_pkg::*;

  logic in_req;
  logic in_end;

  assign in_req = s_tvalid && s_tready;
  assign in_end = in_req && (s_tuser == ACT_END);

  // held result stays put
  `WGM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // an overflowed pattern never matches, pad bits stay zero
  `WGM_ASSERT_NOW(a_no_match_on_ovf, m_tvalid,
                  !(m_tdata[0] && m_tdata[1]) && (m_tdata[OutDataW-1:2] == '0))

  // no result straight out of reset
  `WGM_ASSERT_RST(a_reset_idle, rst, !m_tvalid)

  // a new result needs an accepted end-of-text request, passed through the input register
  `WGM_ASSERT_NOW(a_result_cause, $rose(m_tvalid), $past(in_end, 2))

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
